// ===== rtl/core/pdpwm_pkg.sv =====
// Shared constants, codes and control structures of the percent-duty PWM generator.
`default_nettype none
package pdpwm_pkg;

   localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned ST_W     = 2;
   localparam int unsigned DUTY_W   = 16;
   localparam int unsigned FREQ_W   = 16;
   localparam int unsigned TICK_W   = 20;
   localparam int unsigned PHASE_W  = 21;
   localparam int unsigned PCT_W    = 7;
   localparam int unsigned PROD_W   = TICK_W + PCT_W;
   localparam int unsigned DIVR_W   = 16;
   localparam int unsigned DCNT_W   = $clog2(PROD_W);

   // Division by one hundred: drop two bits, then multiply by the rounded-up reciprocal
   // of 25 scaled by 2^30. The result is exact for every dividend below 2^27.
   localparam int unsigned QIN_W       = PROD_W - 2;
   localparam int unsigned RECIP_W     = 26;
   localparam int unsigned RECIP_SHIFT = 30;
   localparam int unsigned RPROD_W     = QIN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(42949673);

   localparam logic [DUTY_W-1:0] DUTY_MAX    = DUTY_W'(100);

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd1;
   localparam logic [OP_W-1:0] OP_START = 2'd2;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_INIT  = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD_DUTY  = 2'd2;
   localparam logic [ST_W-1:0] ST_ZERO_FREQ = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_req;    // complete a request other than an accepted start
      logic start_load;  // capture an accepted start and begin period division
      logic mul_go;      // capture period and period times duty
      logic div2_go;     // divide period times duty by one hundred
      logic apply_go;    // load the new waveform and respond
   } pd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_ok;
      logic slot_free;
      logic div_done;
   } pd_sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/pdpwm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module pdpwm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pdpwm_pkg::PROD_W-1:0]  dividend,
   input  wire logic [pdpwm_pkg::DIVR_W-1:0]  divisor,
   output logic                               done,
   output logic [pdpwm_pkg::PROD_W-1:0]       quotient
);
   import pdpwm_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [DIVR_W-1:0]   rem_ff, rem_in;
   logic [DIVR_W-1:0]   dvs_ff, dvs_in;
   logic [DIVR_W:0]     trial;
   logic [DIVR_W:0]     diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIVR_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVR_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pdpwm_dp.sv =====
// Datapath: waveform state, period arithmetic and the response register.
`default_nettype none
module pdpwm_dp #(
   parameter int unsigned TICKS_PER_SECOND = pdpwm_pkg::TICKS_PER_SECOND_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pdpwm_pkg::pd_cmd_type         cmd,
   output pdpwm_pkg::pd_sts_type              sts,
   input  wire logic [pdpwm_pkg::OP_W-1:0]    req_op,
   input  wire logic                          req_enable_request,
   input  wire logic [pdpwm_pkg::DUTY_W-1:0]  req_duty_percent,
   input  wire logic [pdpwm_pkg::FREQ_W-1:0]  req_frequency_hz,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_pin_level,
   output logic                               rsp_qualifier_out,
   output logic [pdpwm_pkg::ST_W-1:0]         rsp_status_code
);
   import pdpwm_pkg::*;

   logic                initialized_ff, initialized_in;
   logic                running_ff, running_in;
   logic [TICK_W-1:0]   on_ff, on_in;
   logic [TICK_W-1:0]   off_ff, off_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic                level_ff, level_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_pin_ff, rsp_pin_in;
   logic                rsp_qual_ff, rsp_qual_in;
   logic [ST_W-1:0]     rsp_st_ff, rsp_st_in;
   logic                qual_ff, qual_in;
   logic [PCT_W-1:0]    duty_ff, duty_in;
   logic [TICK_W-1:0]   period_ff, period_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [TICK_W-1:0]   on100_ff, on100_in;

   logic                div_start;
   logic [PROD_W-1:0]   div_dividend;
   logic [DIVR_W-1:0]   div_divisor;
   logic                div_done;
   logic [PROD_W-1:0]   div_quo;

   logic [RPROD_W-1:0]  recip_prod;
   logic [PHASE_W-1:0]  period_sum;
   logic [PHASE_W-1:0]  phase_inc;
   logic [TICK_W-1:0]   new_on;
   logic [TICK_W-1:0]   new_off;
   logic [ST_W-1:0]     start_st;

   pdpwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign div_start    = cmd.start_load;
   assign div_dividend = PROD_W'(TICKS_PER_SECOND);
   assign div_divisor  = req_frequency_hz;

   always_comb begin
      if (!initialized_ff) begin
         start_st = ST_NOT_INIT;
      end else if (req_duty_percent > DUTY_MAX) begin
         start_st = ST_BAD_DUTY;
      end else if (req_frequency_hz == '0) begin
         start_st = ST_ZERO_FREQ;
      end else begin
         start_st = ST_OK;
      end
   end

   assign sts.start_ok  = (req_op == OP_START) && (start_st == ST_OK);
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;
   assign sts.div_done  = div_done;

   assign recip_prod = RPROD_W'(prod_ff[PROD_W-1:2]) * RPROD_W'(RECIP_25);
   assign period_sum = {1'b0, on_ff} + {1'b0, off_ff};
   assign phase_inc  = phase_ff + 1'b1;
   assign new_on     = on100_ff;
   assign new_off    = period_ff - new_on;

   always_comb begin
      initialized_in = initialized_ff;
      running_in     = running_ff;
      on_in          = on_ff;
      off_in         = off_ff;
      phase_in       = phase_ff;
      level_in       = level_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_pin_in     = rsp_pin_ff;
      rsp_qual_in    = rsp_qual_ff;
      rsp_st_in      = rsp_st_ff;
      qual_in        = qual_ff;
      duty_in        = duty_ff;
      period_in      = period_ff;
      prod_in        = prod_ff;
      on100_in       = on100_ff;

      if (cmd.take_req) begin
         rsp_st_in = ST_OK;
         case (req_op)
            OP_TICK: begin
               if (running_ff && (on_ff != '0) && (off_ff != '0)) begin
                  if (phase_inc >= period_sum) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_inc;
                  end
                  level_in = (phase_in < {1'b0, on_ff});
               end
            end
            OP_INIT: begin
               initialized_in = req_enable_request;
               if (!req_enable_request) begin
                  running_in = 1'b0;
                  phase_in   = '0;
                  level_in   = 1'b0;
               end
            end
            OP_START: begin
               // Only rejected starts arrive here; they change no state.
               rsp_st_in = start_st;
            end
            OP_STOP: begin
               if (!initialized_ff) begin
                  rsp_st_in = ST_NOT_INIT;
               end else begin
                  running_in = 1'b0;
                  phase_in   = '0;
                  level_in   = 1'b0;
               end
            end
            default: begin
               rsp_st_in = ST_OK;
            end
         endcase
         rsp_valid_in = 1'b1;
         rsp_pin_in   = level_in;
         rsp_qual_in  = req_enable_request;
      end

      if (cmd.start_load) begin
         qual_in = req_enable_request;
         duty_in = req_duty_percent[PCT_W-1:0];
      end

      if (cmd.mul_go) begin
         period_in = div_quo[TICK_W-1:0];
         prod_in   = PROD_W'(div_quo[TICK_W-1:0]) * PROD_W'(duty_ff);
      end

      if (cmd.div2_go) begin
         on100_in = recip_prod[RECIP_SHIFT +: TICK_W];
      end

      if (cmd.apply_go) begin
         on_in        = new_on;
         off_in       = new_off;
         phase_in     = '0;
         running_in   = 1'b1;
         // A zero off-time holds the pin high; otherwise a zero on-time holds it low.
         level_in     = (new_off == '0) || (new_on != '0);
         rsp_valid_in = 1'b1;
         rsp_pin_in   = level_in;
         rsp_qual_in  = qual_ff;
         rsp_st_in    = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initialized_ff <= 1'b0;
         running_ff     <= 1'b0;
         on_ff          <= '0;
         off_ff         <= '0;
         phase_ff       <= '0;
         level_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         initialized_ff <= initialized_in;
         running_ff     <= running_in;
         on_ff          <= on_in;
         off_ff         <= off_in;
         phase_ff       <= phase_in;
         level_ff       <= level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_pin_ff  <= rsp_pin_in;
      rsp_qual_ff <= rsp_qual_in;
      rsp_st_ff   <= rsp_st_in;
      qual_ff     <= qual_in;
      duty_ff     <= duty_in;
      period_ff   <= period_in;
      prod_ff     <= prod_in;
      on100_ff    <= on100_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_level     = rsp_pin_ff;
   assign rsp_qualifier_out = rsp_qual_ff;
   assign rsp_status_code   = rsp_st_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pdpwm_ctrl.sv =====
// Controller state machine sequencing requests and the start arithmetic.
`default_nettype none
module pdpwm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pdpwm_pkg::pd_sts_type  sts,
   output pdpwm_pkg::pd_cmd_type       cmd
);
   import pdpwm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_DIV1  = 4'b0010,
      S_MUL   = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && sts.slot_free) begin
               if (sts.start_ok) begin
                  cmd.start_load = 1'b1;
                  state_in       = S_DIV1;
               end else begin
                  cmd.take_req = 1'b1;
               end
            end
         end
         S_DIV1: begin
            if (sts.div_done) begin
               cmd.mul_go = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            cmd.div2_go = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            // The new waveform is loaded together with its response.
            if (sts.slot_free) begin
               cmd.apply_go = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = !((state_ff == S_IDLE) && sts.slot_free);

endmodule
`default_nettype wire

// ===== rtl/core/percent_duty_pwm_generator_unit.sv =====
// PWM generator with percent duty: one microsecond tick or event request per item.
// The req_ channel carries requests: op selects tick, init, start or stop, with the
// enable flag, duty in percent and frequency in hertz alongside. Each request gives
// exactly one response on the rsp_ channel: pin level after the request, the enable
// flag echoed, and a status code.
// For tick, init, stop and rejected start requests the response is registered and
// appears the cycle after acceptance, and a new request is accepted every cycle while
// responses are taken.
// An accepted start keeps req_stall high until its response is loaded, and runs through
// 27 restoring divider steps for ticks per second over frequency, a step in which the
// quotient is seen and multiplied by the duty, one in which that product is divided by
// one hundred through a reciprocal multiply, and one that loads the new waveform
// together with its response once the response register is free.
// When rsp_stall is high the response holds in its register and req_stall rises until
// it is taken. Synchronous reset clears the initialized flag, stops the waveform,
// clears the waveform level and empties the response register.
`default_nettype none
module percent_duty_pwm_generator_unit #(
   parameter int unsigned TICKS_PER_SECOND = pdpwm_pkg::TICKS_PER_SECOND_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pdpwm_pkg::OP_W-1:0]    req_op,
   input  wire logic                          req_enable_request,
   input  wire logic [pdpwm_pkg::DUTY_W-1:0]  req_duty_percent,
   input  wire logic [pdpwm_pkg::FREQ_W-1:0]  req_frequency_hz,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_pin_level,
   output logic                               rsp_qualifier_out,
   output logic [pdpwm_pkg::ST_W-1:0]         rsp_status_code
);
   import pdpwm_pkg::*;

   pd_cmd_type cmd;
   pd_sts_type sts;

   pdpwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pdpwm_dp #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_op             (req_op),
      .req_enable_request (req_enable_request),
      .req_duty_percent   (req_duty_percent),
      .req_frequency_hz   (req_frequency_hz),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pin_level      (rsp_pin_level),
      .rsp_qualifier_out  (rsp_qualifier_out),
      .rsp_status_code    (rsp_status_code)
   );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the percent-duty PWM generator: directed table, then random requests.
`default_nettype none
module tb;
   import pdpwm_pkg::*;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned RANDOM_REQUESTS = 500;
   localparam int unsigned DIRECTED_ROWS = 25;

   typedef struct packed {
      logic            pin;
      logic            qual;
      logic [ST_W-1:0] status;
   } pwm_rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              enable;
      logic [DUTY_W-1:0] duty;
      logic [FREQ_W-1:0] freq;
      logic              typed;
      pwm_rsp_type       rsp;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_op = OP_TICK;
   logic              req_enable_request = 1'b0;
   logic [DUTY_W-1:0] req_duty_percent = '0;
   logic [FREQ_W-1:0] req_frequency_hz = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_pin_level;
   logic              rsp_qualifier_out;
   logic [ST_W-1:0]   rsp_status_code;

   // Predicted state of the waveform generator.
   logic               pred_initialized;
   logic               pred_running;
   logic [TICK_W-1:0]  pred_on_ticks;
   logic [TICK_W-1:0]  pred_off_ticks;
   logic [PHASE_W-1:0] pred_phase;
   logic               pred_level;

   pwm_rsp_type  pending_rsp [$];
   stim_row_type directed_rows [DIRECTED_ROWS];
   int           error_count = 0;
   int           idle_cycles = 0;
   bit           calm = 1'b0;
   bit           drain_first = 1'b0;

   percent_duty_pwm_generator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_enable_request (req_enable_request),
      .req_duty_percent   (req_duty_percent),
      .req_frequency_hz   (req_frequency_hz),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pin_level      (rsp_pin_level),
      .rsp_qualifier_out  (rsp_qualifier_out),
      .rsp_status_code    (rsp_status_code)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the predicted waveform by one request and gives the response it should produce.
   task automatic predict_pin(input logic [OP_W-1:0] op, input logic enable,
                              input logic [DUTY_W-1:0] duty, input logic [FREQ_W-1:0] freq,
                              output pwm_rsp_type rsp);
      logic [31:0]      period;
      logic [31:0]      on_time;
      logic [PHASE_W-1:0] span;
      logic [ST_W-1:0]  status;
      status = ST_OK;
      case (op)
         OP_TICK: begin
            if (pred_running && pred_on_ticks != '0 && pred_off_ticks != '0) begin
               span = {1'b0, pred_on_ticks} + {1'b0, pred_off_ticks};
               pred_phase = pred_phase + 1'b1;
               if (pred_phase >= span) pred_phase = '0;
               pred_level = (pred_phase < {1'b0, pred_on_ticks});
            end
         end
         OP_INIT: begin
            if (enable) begin
               pred_initialized = 1'b1;
            end else begin
               pred_initialized = 1'b0;
               pred_running = 1'b0;
               pred_phase = '0;
               pred_level = 1'b0;
            end
         end
         OP_START: begin
            if (!pred_initialized) status = ST_NOT_INIT;
            else if (duty > DUTY_MAX) status = ST_BAD_DUTY;
            else if (freq == '0) status = ST_ZERO_FREQ;
            else begin
               period = TICKS_PER_SECOND_DEF / 32'(freq);
               on_time = (period * 32'(duty)) / 32'd100;
               pred_on_ticks = on_time[TICK_W-1:0];
               pred_off_ticks = TICK_W'(period - on_time);
               pred_phase = '0;
               pred_running = 1'b1;
               // A zero off-time holds the pin high; otherwise the pin is high only with on-time.
               pred_level = (pred_off_ticks == '0) || (pred_on_ticks != '0);
            end
         end
         default: begin
            if (!pred_initialized) begin
               status = ST_NOT_INIT;
            end else begin
               pred_running = 1'b0;
               pred_phase = '0;
               pred_level = 1'b0;
            end
         end
      endcase
      rsp.pin = pred_level;
      rsp.qual = enable;
      rsp.status = status;
   endtask

   task automatic send_request(input logic [OP_W-1:0] op, input logic enable,
                               input logic [DUTY_W-1:0] duty, input logic [FREQ_W-1:0] freq,
                               input logic typed, input pwm_rsp_type typed_rsp);
      int          gap;
      pwm_rsp_type want;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (drain_first && gap == 0) gap = 1;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         while (drain_first && pending_rsp.size() != 0) @(posedge clock);
         drain_first = 1'b0;
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_enable_request <= enable;
      req_duty_percent <= duty;
      req_frequency_hz <= freq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pin(op, enable, duty, freq, want);
      if (typed) want = typed_rsp;
      pending_rsp.push_back(want);
   endtask

   // Request source: reset, directed table, random traffic, then the drain at the end.
   initial begin
      logic [OP_W-1:0]   op;
      logic              enable;
      logic [DUTY_W-1:0] duty;
      logic [FREQ_W-1:0] freq;
      int                pick;
      pred_initialized = 1'b0;
      pred_running = 1'b0;
      pred_on_ticks = '0;
      pred_off_ticks = '0;
      pred_phase = '0;
      pred_level = 1'b0;
      directed_rows = '{
         '{OP_TICK,  1'b0, 16'd0,     16'd0,     1'b1, '{1'b0, 1'b0, ST_OK}},
         '{OP_START, 1'b1, 16'd50,    16'd1000,  1'b1, '{1'b0, 1'b1, ST_NOT_INIT}},
         '{OP_STOP,  1'b0, 16'hFFFF,  16'hFFFF,  1'b1, '{1'b0, 1'b0, ST_NOT_INIT}},
         '{OP_INIT,  1'b1, 16'd0,     16'd0,     1'b1, '{1'b0, 1'b1, ST_OK}},
         '{OP_START, 1'b0, 16'd101,   16'd1000,  1'b1, '{1'b0, 1'b0, ST_BAD_DUTY}},
         '{OP_START, 1'b1, 16'hFFFF,  16'd0,     1'b1, '{1'b0, 1'b1, ST_BAD_DUTY}},
         '{OP_START, 1'b1, 16'd50,    16'd0,     1'b1, '{1'b0, 1'b1, ST_ZERO_FREQ}},
         '{OP_START, 1'b1, 16'd100,   16'hFFFF,  1'b1, '{1'b1, 1'b1, ST_OK}},
         '{OP_TICK,  1'b1, 16'd0,     16'd0,     1'b1, '{1'b1, 1'b1, ST_OK}},
         '{OP_START, 1'b0, 16'd0,     16'd1,     1'b1, '{1'b0, 1'b0, ST_OK}},
         '{OP_TICK,  1'b0, 16'd0,     16'd0,     1'b1, '{1'b0, 1'b0, ST_OK}},
         '{OP_START, 1'b1, 16'd1,     16'hFFFF,  1'b1, '{1'b0, 1'b1, ST_OK}},
         '{OP_START, 1'b1, 16'd100,   16'd1,     1'b1, '{1'b1, 1'b1, ST_OK}},
         '{OP_START, 1'b0, 16'd50,    16'hFFFF,  1'b0, '0},
         '{OP_TICK,  1'b1, 16'hFFFF,  16'hFFFF,  1'b0, '0},
         '{OP_TICK,  1'b0, 16'd0,     16'd0,     1'b0, '0},
         '{OP_TICK,  1'b1, 16'd0,     16'd0,     1'b0, '0},
         '{OP_TICK,  1'b0, 16'd0,     16'd0,     1'b0, '0},
         '{OP_TICK,  1'b0, 16'd0,     16'd0,     1'b0, '0},
         '{OP_TICK,  1'b0, 16'd0,     16'd0,     1'b0, '0},
         '{OP_INIT,  1'b1, 16'd0,     16'd0,     1'b0, '0},
         '{OP_TICK,  1'b0, 16'd0,     16'd0,     1'b0, '0},
         '{OP_STOP,  1'b1, 16'd0,     16'd0,     1'b1, '{1'b0, 1'b1, ST_OK}},
         '{OP_INIT,  1'b0, 16'd0,     16'd0,     1'b1, '{1'b0, 1'b0, ST_OK}},
         '{OP_START, 1'b1, 16'd20,    16'd50000, 1'b1, '{1'b0, 1'b1, ST_NOT_INIT}}
      };
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].enable, directed_rows[i].duty,
                      directed_rows[i].freq, directed_rows[i].typed, directed_rows[i].rsp);
      end

      for (int k = 0; k < RANDOM_REQUESTS; k++) begin
         if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if (k == RANDOM_REQUESTS / 2) drain_first = 1'b1;
         enable = 1'($urandom_range(0, 1));
         duty = DUTY_W'($urandom_range(0, 16'hFFFF));
         freq = FREQ_W'($urandom_range(0, 16'hFFFF));
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            op = OP_TICK;
         end else if (pick < 82) begin
            op = OP_START;
            // Mostly well-formed starts with short periods, so that ticks wrap the waveform.
            case ($urandom_range(0, 9))
               0: duty = DUTY_W'($urandom_range(101, 16'hFFFF));
               1: freq = '0;
               2: duty = DUTY_W'($urandom_range(0, 100));
               default: begin
                  duty = DUTY_W'($urandom_range(0, 100));
                  freq = FREQ_W'($urandom_range(10000, 16'hFFFF));
               end
            endcase
         end else if (pick < 92) begin
            op = OP_INIT;
            enable = ($urandom_range(0, 4) != 0);
         end else begin
            op = OP_STOP;
         end
         send_request(op, enable, duty, freq, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("percent_duty_pwm_generator_unit test passed");
      end else begin
         $display("percent_duty_pwm_generator_unit test failed");
      end
      $finish;
   end

   // Response sink with random back-pressure, checked against the oldest prediction.
   initial begin
      int          hold;
      pwm_rsp_type want;
      do @(posedge clock); while (reset);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 4);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_pin_level !== want.pin) begin
               $error("pin_level: expected %0d, got %0d", want.pin, rsp_pin_level);
               error_count++;
            end
            if (rsp_qualifier_out !== want.qual) begin
               $error("qualifier_out: expected %0d, got %0d", want.qual, rsp_qualifier_out);
               error_count++;
            end
            if (rsp_status_code !== want.status) begin
               $error("status_code: expected %0d, got %0d", want.status, rsp_status_code);
               error_count++;
            end
         end
      end
   end

   // Ends the run if neither channel completes a handshake for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("percent_duty_pwm_generator_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/pdpwm_pkg.sv
rtl/core/pdpwm_div.sv
rtl/core/pdpwm_dp.sv
rtl/core/pdpwm_ctrl.sv
rtl/core/percent_duty_pwm_generator_unit.sv
tb/sv/tb.sv
